/* rtl/nlf_pkg.sv */
// ----------------------------------------------------------------------------
// nlf_pkg
// Shared types and constants of the nonlinear ladder low-pass filter.
// ----------------------------------------------------------------------------
package nlf_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int TANH_DEPTH_DEF   = 256;

    // Internal state word, Q4.20
    localparam int ST_W = 24;

    // 0.3 in Q0.16
    localparam logic [15:0] COUPLE_Q16 = 16'd19661;

    localparam logic [15:0] CUTOFF_RESET = 16'd1584;
    localparam logic [15:0] RES_RESET    = 16'd0;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_CUTOFF = 1'b0;
    localparam logic REG_RES    = 1'b1;

    typedef struct packed {
        logic [15:0] cutoff;
        logic [15:0] res;
    } cfg_t;

endpackage

/* rtl/nlf_tanh_rom.sv */
// ----------------------------------------------------------------------------
// nlf_tanh_rom
// Tanh table in Q4.20 with a registered read of two neighboring entries.
// ----------------------------------------------------------------------------
module nlf_tanh_rom #(
    parameter int DEPTH = nlf_pkg::TANH_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic [$clog2(DEPTH)-1:0]      addr,
    output logic signed [nlf_pkg::ST_W-1:0] lo_reg,
    output logic signed [nlf_pkg::ST_W-1:0] hi_reg
);
    import nlf_pkg::*;

    localparam int IW = $clog2(DEPTH);

    typedef logic signed [ST_W-1:0] tab_t [DEPTH+1];

    // Long division of non-negative operands by shift and subtract.
    function automatic longint udiv(longint num, longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--)
        begin
            r = (r <<< 1) | ((num >>> b) & 64'sd1);
            if (r >= den)
            begin
                r = r - den;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    // Entry i is tanh(8i/DEPTH): exp(-16i/DEPTH) from a ten-term series on
    // a small argument, squared six times, then (1-e)/(1+e) rounded.
    function automatic tab_t build_tab();
        tab_t   t;
        longint one;
        longint w;
        longint term;
        longint e;
        one = 64'sd1 <<< 31;
        for (int i = 0; i <= DEPTH; i++)
        begin
            w    = udiv(longint'(i) <<< 29, longint'(DEPTH));
            term = one;
            e    = one;
            for (int k = 1; k <= 10; k++)
            begin
                term = udiv((term * w) >>> 31, longint'(k));
                e    = k[0] ? e - term : e + term;
            end
            for (int k = 0; k < 6; k++)
            begin
                e = (e * e) >>> 31;
            end
            t[i] = ST_W'(udiv(((one - e) <<< 20) + ((one + e) >>> 1), one + e));
        end
        return t;
    endfunction

    localparam tab_t TAB = build_tab();

    logic [IW:0] addr_hi;

    assign addr_hi = (IW + 1)'(addr) + (IW + 1)'(1);

    always_ff @(posedge clk)
    begin
        lo_reg <= TAB[addr];
        hi_reg <= TAB[addr_hi];
    end

endmodule

/* rtl/nlf_core.sv */
// ----------------------------------------------------------------------------
// nlf_core
// Sequencer and shared multiplier that run two ladder ticks per sample.
// ----------------------------------------------------------------------------
module nlf_core #(
    parameter int SAMPLE_WIDTH = nlf_pkg::SAMPLE_WIDTH_DEF,
    parameter int TANH_DEPTH   = nlf_pkg::TANH_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nlf_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
    output logic                           out_valid_reg,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_sample_reg
);
    import nlf_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int IW = $clog2(TANH_DEPTH);
    localparam int WW = SW + 8;
    localparam int VW = 28;
    localparam int MW = 25;
    localparam int PW = 49;

    localparam int SH_MID = SW - 20;
    localparam int MID_UP = (SH_MID < 0) ? -SH_MID : 0;
    localparam int MID_DN = (SH_MID > 0) ? SH_MID : 0;
    localparam int SH_IN  = SW - 21;
    localparam int IN_UP  = (SH_IN < 0) ? -SH_IN : 0;
    localparam int IN_DN  = (SH_IN > 0) ? SH_IN : 0;
    localparam int OW     = ST_W + 1 + IN_UP + IN_DN;

    localparam logic signed [OW-1:0] OMAX = OW'((64'sd1 <<< (SW - 1)) - 1);
    localparam logic signed [OW-1:0] OMIN = OW'(-(64'sd1 <<< (SW - 1)));
    localparam logic signed [ST_W+9:0] SMAX = (ST_W + 10)'((64'sd1 <<< (ST_W - 1)) - 1);
    localparam logic signed [ST_W+9:0] SMIN = (ST_W + 10)'(-(64'sd1 <<< (ST_W - 1)));
    localparam logic [22:0] CLAMP = 23'h7fffff;

    typedef enum logic [3:0] {
        S_IDLE, S_FB, S_V, S_TA, S_TB, S_TC, S_TD,
        S_CPL, S_ARG, S_FD, S_UPD, S_DONE
    } state_t;

    typedef enum logic [1:0] {K_DRIVE, K_ARG, K_Y} kind_t;

    state_t state_reg;
    kind_t  kind_reg;
    logic   tick_reg;
    logic [1:0] stg_reg;

    logic signed [ST_W-1:0] y_reg [4];
    logic signed [ST_W-1:0] p_reg [4];
    logic signed [SW-1:0]   last_reg;
    logic signed [SW-1:0]   x_reg;
    logic signed [ST_W-1:0] u_reg;
    logic signed [ST_W-1:0] drive_reg;
    logic signed [ST_W-1:0] targ_reg;
    logic signed [ST_W-1:0] diff_reg;
    logic signed [VW-1:0]   v_reg;
    logic [22:0]            a_reg;
    logic                   neg_reg;
    logic [22:0]            frac_reg;
    logic signed [PW-1:0]   prod_reg;

    logic signed [ST_W-1:0] lo_reg;
    logic signed [ST_W-1:0] hi_reg;

    logic signed [MW-1:0]   mul_a;
    logic signed [ST_W-1:0] mul_b;
    logic signed [PW-1:0]   prod_next;

    logic [23+IW:0]         tp;
    logic [VW-1:0]          absv;
    logic signed [WW-1:0]   mid_w;
    logic signed [WW-1:0]   in_w;
    logic signed [ST_W-1:0] u_mid;
    logic signed [ST_W-1:0] u_in;
    logic signed [25:0]     interp;
    logic signed [ST_W-1:0] tres;
    logic signed [ST_W+9:0] upd;
    logic signed [ST_W-1:0] nxt;
    logic signed [OW-1:0]   o_w;
    logic signed [SW-1:0]   o_sat;

    nlf_tanh_rom #(
        .DEPTH(TANH_DEPTH)
    ) u_rom (
        .clk   (clk),
        .addr  (tp[23+IW-1:23]),
        .lo_reg(lo_reg),
        .hi_reg(hi_reg)
    );

    // Shared multiplier; operands follow the sequencer step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_FB:
            begin
                mul_a = MW'($signed({1'b0, cfg.res}));
                mul_b = y_reg[3];
            end
            S_CPL:
            begin
                mul_a = MW'($signed({1'b0, COUPLE_Q16}));
                mul_b = p_reg[stg_reg];
            end
            S_TC:
            begin
                mul_a = MW'(hi_reg) - MW'(lo_reg);
                mul_b = $signed({1'b0, frac_reg});
            end
            S_FD:
            begin
                mul_a = MW'($signed({1'b0, cfg.cutoff}));
                mul_b = diff_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);

    assign absv  = v_reg[VW-1] ? VW'(-v_reg) : VW'(v_reg);
    assign tp    = (24 + IW)'(a_reg) * (24 + IW)'(TANH_DEPTH);

    assign mid_w = ((WW'(last_reg) + WW'(in_sample)) <<< MID_UP) >>> MID_DN;
    assign in_w  = (WW'(x_reg) <<< IN_UP) >>> IN_DN;
    assign u_mid = ST_W'(mid_w);
    assign u_in  = ST_W'(in_w);

    assign interp = 26'(lo_reg) + prod_reg[48:23];
    assign tres   = neg_reg ? ST_W'(-interp) : ST_W'(interp);

    assign upd = (ST_W + 10)'(y_reg[stg_reg]) + (ST_W + 10)'($signed(prod_reg[48:16]));
    assign nxt = (upd > SMAX) ? ST_W'(SMAX) : ((upd < SMIN) ? ST_W'(SMIN) : ST_W'(upd));

    // The state is Q4.20, so the output scales the other way from the input.
    assign o_w   = (OW'(y_reg[3]) <<< IN_DN) >>> IN_UP;
    assign o_sat = (o_w > OMAX) ? SW'(OMAX) : ((o_w < OMIN) ? SW'(OMIN) : SW'(o_w));

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= K_DRIVE;
            tick_reg       <= 1'b0;
            stg_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            last_reg       <= '0;
            x_reg          <= '0;
            u_reg          <= '0;
            drive_reg      <= '0;
            targ_reg       <= '0;
            diff_reg       <= '0;
            v_reg          <= '0;
            a_reg          <= '0;
            neg_reg        <= 1'b0;
            frac_reg       <= '0;
            prod_reg       <= '0;
            for (int i = 0; i < 4; i++)
            begin
                y_reg[i] <= '0;
                p_reg[i] <= '0;
            end
        end
        else
        begin
            prod_reg <= prod_next;
            if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg     <= in_sample;
                        u_reg     <= u_mid;
                        tick_reg  <= 1'b0;
                        state_reg <= S_FB;
                    end
                end
                S_FB:
                begin
                    state_reg <= S_V;
                end
                S_V:
                begin
                    v_reg     <= VW'(u_reg) - VW'(prod_reg[48:14]);
                    kind_reg  <= K_DRIVE;
                    state_reg <= S_TA;
                end
                S_TA:
                begin
                    neg_reg   <= v_reg[VW-1];
                    a_reg     <= (absv > VW'(CLAMP)) ? CLAMP : absv[22:0];
                    state_reg <= S_TB;
                end
                S_TB:
                begin
                    frac_reg  <= tp[22:0];
                    state_reg <= S_TC;
                end
                S_TC:
                begin
                    state_reg <= S_TD;
                end
                S_TD:
                begin
                    case (kind_reg)
                        K_DRIVE:
                        begin
                            drive_reg <= tres;
                            stg_reg   <= '0;
                            state_reg <= S_CPL;
                        end
                        K_ARG:
                        begin
                            targ_reg  <= tres;
                            v_reg     <= VW'(y_reg[stg_reg]);
                            kind_reg  <= K_Y;
                            state_reg <= S_TA;
                        end
                        default:
                        begin
                            diff_reg  <= targ_reg - tres;
                            state_reg <= S_FD;
                        end
                    endcase
                end
                S_CPL:
                begin
                    state_reg <= S_ARG;
                end
                S_ARG:
                begin
                    v_reg     <= VW'(drive_reg) + VW'(prod_reg[48:16]);
                    kind_reg  <= K_ARG;
                    state_reg <= S_TA;
                end
                S_FD:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    y_reg[stg_reg] <= nxt;
                    p_reg[stg_reg] <= drive_reg;
                    drive_reg      <= nxt;
                    if (stg_reg == 2'd3)
                    begin
                        if (!tick_reg)
                        begin
                            tick_reg  <= 1'b1;
                            u_reg     <= u_in;
                            state_reg <= S_FB;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        stg_reg   <= stg_reg + 2'd1;
                        state_reg <= S_CPL;
                    end
                end
                S_DONE:
                begin
                    // Hold the finished word until the output register is free.
                    if (!out_valid_reg || out_ready)
                    begin
                        out_sample_reg <= o_sat;
                        last_reg       <= x_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/nonlinear_ladder_lowpass_filter.sv */
// ----------------------------------------------------------------------------
// nonlinear_ladder_lowpass_filter
// Four-stage nonlinear ladder low-pass, two ticks per sample, fixed point.
//
//   Channel   Direction  Signals                          Payload
//   s_axis    in         s_tvalid s_tready s_tdata        sample_in
//   m_axis    out        m_tvalid m_tready m_tdata        sample_out
//   apb       in/out     psel penable pwrite paddr ...    cutoff, resonance
//
// Each sample runs two ladder ticks on the single shared multiplier, and the
// interpolated tanh runs nine times per tick. The sequencer then loads the
// output register and returns to idle. s_tready is high only while the
// sequencer is idle. A finished word waits in the output register; the next
// sample may be accepted meanwhile.
// rst_n clears the ladder state and loads the register reset values.
// ----------------------------------------------------------------------------
module nonlinear_ladder_lowpass_filter #(
    parameter int SAMPLE_WIDTH = nlf_pkg::SAMPLE_WIDTH_DEF,
    parameter int TANH_DEPTH   = nlf_pkg::TANH_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // [SW-1:0] sample_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,  // [SW-1:0] sample_out
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import nlf_pkg::*;

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    logic [15:0] cutoff_reg;
    logic [15:0] res_reg;
    cfg_t        cfg;
    logic        wr_en;
    logic signed [SAMPLE_WIDTH-1:0] out_sample;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUTOFF_RESET;
            res_reg    <= RES_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_CUTOFF)
            begin
                cutoff_reg <= pwdata[15:0];
            end
            else
            begin
                res_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata     = {16'd0, (paddr[2] == REG_RES) ? res_reg : cutoff_reg};
    assign cfg.cutoff = cutoff_reg;
    assign cfg.res    = res_reg;

    nlf_core #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .TANH_DEPTH  (TANH_DEPTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_sample     ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
        .out_valid_reg (m_tvalid),
        .out_ready     (m_tready),
        .out_sample_reg(out_sample)
    );

    assign m_tdata = TDATA_W'(unsigned'(out_sample));

endmodule

/* rtl/nlf_checker.sv */
// ----------------------------------------------------------------------------
// nlf_checker
// Port-level checks of the ladder filter, bound to the top level.
// ----------------------------------------------------------------------------
module nlf_checker #(
    parameter int TDATA_W = 24
) (
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [31:0]        prdata,
    input logic               pready
);

    // A stalled output word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // After a sample is taken, s_tready stays low while the sequencer is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input taken again too soon");

    // No result is produced in the cycle right after a sample is taken
    // unless an older word was already waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared without computation time");

    // Registers are 16 bits wide and the port never waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        pready && prdata[31:16] == 16'd0)
        else $error("register port misbehaves");

endmodule

bind nonlinear_ladder_lowpass_filter nlf_checker #(
    .TDATA_W(TDATA_W)
) u_nlf_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .prdata  (prdata),
    .pready  (pready)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nonlinear ladder low-pass filter. Samples are
// streamed in bursts while the output side stalls at random. A fixed-point
// model of the two-tick ladder predicts every output word, and each word is
// compared with it in order. Cutoff and resonance are changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import nlf_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEF;
    localparam int DEPTH = TANH_DEPTH_DEF;
    localparam longint ST_HI = 64'sd8388607;
    localparam longint ST_LO = -64'sd8388608;
    localparam int DRAIN_CYCLES = 240;
    localparam int RANDOM_WORDS = 880;

    typedef struct {
        logic [SW-1:0] sample;
        bit            known;
        logic [SW-1:0] result;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [23:0]   s_tdata;   // [23:0] sample_in
    logic          m_tvalid;
    logic          m_tready;
    logic [23:0]   m_tdata;   // [23:0] sample_out
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    longint        tanh_lut[DEPTH+1];
    longint        y_stage[4];
    longint        in_prev[4];
    longint        prev_sample;
    longint        gain_f;
    longint        gain_res;
    logic [SW-1:0] filtered_q[$];
    int            errors;
    bit            long_hold;

    nonlinear_ladder_lowpass_filter dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // tanh(8i/D) in Q4.20, from a series for a small exponent squared six times.
    function automatic void build_tanh_lut();
        longint w, term, e;
        for (int i = 0; i <= DEPTH; i++)
        begin
            w = (longint'(i) <<< 29) / DEPTH;
            term = 64'sd1 <<< 31;
            e = term;
            for (int k = 1; k <= 10; k++)
            begin
                term = ((term * w) >>> 31) / k;
                e = (k % 2 == 1) ? e - term : e + term;
            end
            for (int k = 0; k < 6; k++)
                e = (e * e) >>> 31;
            tanh_lut[i] = ((((64'sd1 <<< 31) - e) <<< 20) + ((64'sd1 <<< 31) + e) / 2)
                          / ((64'sd1 <<< 31) + e);
        end
    endfunction

    function automatic longint tanh_q20(longint v);
        longint a, p, idx, frac, r;
        a = v < 0 ? -v : v;
        if (a > ST_HI)
            a = ST_HI;
        p = a * DEPTH;
        idx = p >>> 23;
        frac = p & ((64'sd1 <<< 23) - 1);
        r = tanh_lut[idx] + (((tanh_lut[idx+1] - tanh_lut[idx]) * frac) >>> 23);
        return v < 0 ? -r : r;
    endfunction

    function automatic void ladder_tick(longint u);
        longint drive, arg, diff;
        longint nxt[4];
        drive = tanh_q20(u - ((gain_res * y_stage[3]) >>> 14));
        for (int s = 0; s < 4; s++)
        begin
            arg = drive + ((longint'(COUPLE_Q16) * in_prev[s]) >>> 16);
            diff = tanh_q20(arg) - tanh_q20(y_stage[s]);
            nxt[s] = clamp(y_stage[s] + ((gain_f * diff) >>> 16), ST_LO, ST_HI);
            in_prev[s] = drive;
            drive = nxt[s];
        end
        for (int s = 0; s < 4; s++)
            y_stage[s] = nxt[s];
    endfunction

    // Two ticks per sample: midpoint first, then the sample itself.
    function automatic logic [SW-1:0] filter_sample(logic [SW-1:0] raw);
        longint x;
        x = longint'(signed'(raw));
        ladder_tick((prev_sample + x) >>> (SW - 20));
        ladder_tick(x >>> (SW - 21));
        prev_sample = x;
        return SW'(clamp(y_stage[3] * (64'sd1 <<< (SW - 21)), ST_LO, ST_HI));
    endfunction

    task automatic apb_write(logic idx, logic [15:0] value);
        logic [31:0] got;
        // The sequencer is already idle by the time the last word leaves.
        wait (filtered_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom_range(0, 65535)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_CUTOFF)
            gain_f = value;
        else
            gain_res = value;
        if (got[15:0] !== value)
        begin
            $error("register readback: expected %h, got %h", value, got[15:0]);
            errors++;
        end
    endtask

    task automatic send_word(logic [SW-1:0] sample, int gap);
        s_tvalid <= 1'b1;
        s_tdata <= sample;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        filtered_q.push_back(filter_sample(sample));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int burst_gap(ref int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 12);
        return $urandom_range(1, 150);
    endfunction

    // Output checker.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (filtered_q.size() == 0)
            begin
                $error("sample_out: unexpected word %h", m_tdata);
                errors++;
            end
            else
            begin
                if (m_tdata[SW-1:0] !== filtered_q[0])
                begin
                    $error("sample_out: expected %h, got %h", filtered_q[0], m_tdata);
                    errors++;
                end
                void'(filtered_q.pop_front());
            end
        end
    end

    // Output stall pattern, with stretches of no stalls and one long hold.
    initial
    begin
        int mode;
        m_tready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 300))
            begin
                @(posedge clk);
                if (long_hold)
                begin
                    m_tready <= 1'b0;
                    repeat (1500) @(posedge clk);
                    long_hold = 1'b0;
                end
                else
                    m_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        logic [15:0] cut_set[6];
        logic [15:0] res_set[6];
        int burst_left;
        logic [SW-1:0] smp;

        errors = 0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        build_tanh_lut();
        for (int s = 0; s < 4; s++)
        begin
            y_stage[s] = 0;
            in_prev[s] = 0;
        end
        prev_sample = 0;
        gain_f = CUTOFF_RESET;
        gain_res = RES_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Silence after reset gives silence; the rest comes from the model.
        rows.push_back('{24'h000000, 1'b1, 24'h000000});
        rows.push_back('{24'h000000, 1'b1, 24'h000000});
        rows.push_back('{24'h7FFFFF, 1'b0, '0});
        rows.push_back('{24'h7FFFFF, 1'b0, '0});
        rows.push_back('{24'h800000, 1'b0, '0});
        rows.push_back('{24'h800000, 1'b0, '0});
        rows.push_back('{24'h000001, 1'b0, '0});
        rows.push_back('{24'hFFFFFF, 1'b0, '0});
        rows.push_back('{24'h555555, 1'b0, '0});
        rows.push_back('{24'hAAAAAA, 1'b0, '0});
        rows.push_back('{24'h7FFFFF, 1'b0, '0});
        rows.push_back('{24'h800000, 1'b0, '0});
        foreach (rows[r])
        begin
            send_word(rows[r].sample, $urandom_range(0, 3));
            if (rows[r].known)
                filtered_q[$] = rows[r].result;
        end
        s_tvalid <= 1'b0;

        // Large gain drives the stages into saturation on full-scale swings.
        apb_write(REG_CUTOFF, 16'hFFFF);
        apb_write(REG_RES, 16'hFFFF);
        for (int i = 0; i < 12; i++)
            send_word(i[0] ? 24'h800000 : 24'h7FFFFF, 0);
        s_tvalid <= 1'b0;

        cut_set = '{16'd0, 16'd1584, 16'd30000, 16'hFFFF, 16'd200, 16'd8000};
        res_set = '{16'hFFFF, 16'd0, 16'd40000, 16'd20000, 16'hFFFF, 16'd1};
        burst_left = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            apb_write(REG_CUTOFF, (ph == 5) ? 16'($urandom) : cut_set[ph]);
            apb_write(REG_RES, (ph == 5) ? 16'($urandom) : res_set[ph]);
            if (ph == 2)
                long_hold = 1'b1;
            for (int i = 0; i < RANDOM_WORDS / 6; i++)
            begin
                case ($urandom_range(0, 5))
                    0: smp = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                    1: smp = SW'($signed($urandom_range(0, 4000)) - 2000);
                    default: smp = SW'($urandom);
                endcase
                send_word(smp, burst_gap(burst_left));
            end
            s_tvalid <= 1'b0;
        end

        wait (filtered_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

/* nonlinear_ladder_lowpass_filter.f */
rtl/nlf_pkg.sv
rtl/nlf_tanh_rom.sv
rtl/nlf_core.sv
rtl/nonlinear_ladder_lowpass_filter.sv
rtl/nlf_checker.sv
tb/sv/tb_top.sv
